>>> rtl/ahfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_pkg: shared constants and types of the ASCII hex frame receiver
// Frame geometry, character codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ahfr_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int SN_POSITION = 1;

	// Byte index and digit count widths. The digit count spans 2*FRAME_BYTES.
	localparam int IDX_W = $clog2(FRAME_BYTES);
	localparam int POS_W = IDX_W + 1;

	localparam bit SN_VALID = (SN_POSITION < FRAME_BYTES);
	localparam int SN_IDX   = SN_VALID ? SN_POSITION : 0;

	localparam logic [7:0] CH_START = 8'h3C;
	localparam logic [7:0] CH_HEAD  = 8'h46;
	localparam logic [7:0] CH_END   = 8'h3E;

	typedef struct packed {
		logic             hi_we;
		logic             lo_we;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] rd_idx;
		logic             last;
	} ahfr_cmd_t;

	typedef struct packed {
		logic is_start;
		logic is_head;
		logic is_end;
	} ahfr_status_t;

endpackage

>>> rtl/ahfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_ctrl: frame receiver controller
// Tracks the frame phase and digit count, then walks the buffer on emit.
// ----------------------------------------------------------------------------
module ahfr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  ahfr_pkg::ahfr_status_t status,
	output ahfr_pkg::ahfr_cmd_t   cmd
);

	localparam logic [2:0] ST_HUNT   = 3'd0;
	localparam logic [2:0] ST_HEADER = 3'd1;
	localparam logic [2:0] ST_DATA   = 3'd2;
	localparam logic [2:0] ST_END    = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	localparam logic [ahfr_pkg::IDX_W-1:0] LAST_IDX =
		ahfr_pkg::IDX_W'(ahfr_pkg::FRAME_BYTES - 1);

	logic [2:0]                   state_q;
	logic [ahfr_pkg::POS_W-1:0]   pos_q;
	logic [ahfr_pkg::IDX_W-1:0]   emit_q;
	logic                         in_acc;
	logic                         out_take;
	logic [ahfr_pkg::IDX_W-1:0]   pair_idx;

	assign in_stall  = (state_q == ST_EMIT);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = out_valid && !out_stall;
	assign pair_idx  = pos_q[ahfr_pkg::POS_W-1:1];

	always_comb begin
		cmd.hi_we  = in_acc && !status.is_start && (state_q == ST_DATA) && !pos_q[0];
		cmd.lo_we  = in_acc && !status.is_start && (state_q == ST_DATA) && pos_q[0];
		cmd.wr_idx = pair_idx;
		cmd.rd_idx = emit_q;
		cmd.last   = (emit_q == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			pos_q   <= '0;
			emit_q  <= '0;
		end else if (state_q == ST_EMIT) begin
			if (out_take) begin
				if (emit_q == LAST_IDX) begin
					state_q <= ST_HUNT;
				end else begin
					emit_q <= emit_q + 1'b1;
				end
			end
		end else if (in_acc) begin
			if (status.is_start) begin
				// A start character restarts the frame from any phase.
				state_q <= ST_HEADER;
				pos_q   <= '0;
			end else begin
				case (state_q)
					ST_HEADER: begin
						state_q <= status.is_head ? ST_DATA : ST_HUNT;
						pos_q   <= '0;
					end
					ST_DATA: begin
						if (pos_q[0] && (pair_idx == LAST_IDX)) begin
							state_q <= ST_END;
							pos_q   <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
					ST_END: begin
						pos_q   <= '0;
						emit_q  <= '0;
						state_q <= status.is_end ? ST_EMIT : ST_HUNT;
					end
					default: begin
						state_q <= ST_HUNT;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/ahfr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_dpath: frame receiver datapath
// Classifies characters, decodes hex digit pairs and holds the frame buffer.
// ----------------------------------------------------------------------------
module ahfr_dpath (
	input  logic                   clk,
	input  logic [7:0]             rx_char,
	input  ahfr_pkg::ahfr_cmd_t    cmd,
	output ahfr_pkg::ahfr_status_t status,
	output logic [7:0]             frame_byte,
	output logic [2:0]             byte_position,
	output logic                   last_byte,
	output logic [7:0]             sequence_byte
);

	logic [7:0] store_q [ahfr_pkg::FRAME_BYTES];
	logic [3:0] hi_nib_q;
	logic [3:0] cur_nib;

	// Characters other than 0-9, A-F and a-f decode as zero.
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [3:0] n;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			n = c[3:0] + 4'd9;
		end else begin
			n = 4'd0;
		end
		return n;
	endfunction

	assign cur_nib = nibble_of(rx_char);

	always_comb begin
		status.is_start = (rx_char == ahfr_pkg::CH_START);
		status.is_head  = (rx_char == ahfr_pkg::CH_HEAD);
		status.is_end   = (rx_char == ahfr_pkg::CH_END);
	end

	always_ff @(posedge clk) begin
		if (cmd.hi_we) begin
			hi_nib_q <= cur_nib;
		end
		if (cmd.lo_we) begin
			store_q[cmd.wr_idx] <= {hi_nib_q, cur_nib};
		end
	end

	assign frame_byte    = store_q[cmd.rd_idx];
	assign byte_position = 3'(cmd.rd_idx);
	assign last_byte     = cmd.last;
	assign sequence_byte = ahfr_pkg::SN_VALID ? store_q[ahfr_pkg::SN_IDX] : 8'h00;

endmodule

>>> rtl/ascii_hex_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver: decodes '<' 'F' hex... '>' frames into bytes
// Top level joining the frame controller and the decoding datapath.
// ----------------------------------------------------------------------------
// One received character is taken per clock cycle while the block is parsing.
// After a frame closes with a good '>', the block presents the FRAME_BYTES
// decoded bytes one per cycle (longer when the output stalls), walked out of
// the frame buffer by the emit counter; the input is stalled for that whole
// run. Every result carries its byte position, a last flag on the final
// byte and the byte at the sequence position. Bad headers or terminators
// drop silently.
module ascii_hex_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic [2:0] byte_position,
	output logic       last_byte,
	output logic [7:0] sequence_byte
);

	ahfr_pkg::ahfr_cmd_t    cmd;
	ahfr_pkg::ahfr_status_t status;

	ahfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ahfr_dpath u_dpath (
		.clk           (clk),
		.rx_char       (rx_char),
		.cmd           (cmd),
		.status        (status),
		.frame_byte    (frame_byte),
		.byte_position (byte_position),
		.last_byte     (last_byte),
		.sequence_byte (sequence_byte)
	);

endmodule

>>> tb/ascii_hex_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_tb: self-checking bench for the hex frame receiver
// Feeds directed and random character streams: good frames, broken headers,
// broken terminators, restarts and noise. A cycle-free model of the parser
// predicts the decoded byte runs, and each output item is checked against it.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {
	PH_HUNT,
	PH_HEADER,
	PH_DATA,
	PH_TERM
} parse_phase_t;

typedef struct packed {
	logic [7:0] data;
	logic [2:0] pos;
	logic       last;
	logic [7:0] seq;
} frame_result_t;

class frame_byte_checker;
	parse_phase_t  phase;
	int            digit_count;
	logic [7:0]    high_char;
	logic [7:0]    decoded[ahfr_pkg::FRAME_BYTES];
	frame_result_t expected_bytes[$];
	int            errors;

	function new();
		phase       = PH_HUNT;
		digit_count = 0;
		high_char   = 8'h00;
		errors      = 0;
		foreach (decoded[i]) decoded[i] = 8'h00;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	function logic [3:0] digit_value(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 10);
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 10);
		return 4'h0;
	endfunction

	// Advances the parser by one accepted character and queues any byte run.
	function void take_char(logic [7:0] c);
		frame_result_t r;
		logic [7:0]    seq_byte;
		int            idx;
		if (c == ahfr_pkg::CH_START) begin
			phase       = PH_HEADER;
			digit_count = 0;
			return;
		end
		case (phase)
			PH_HUNT: begin
			end
			PH_HEADER: begin
				if (c == ahfr_pkg::CH_HEAD) begin
					phase       = PH_DATA;
					digit_count = 0;
				end else begin
					phase = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (digit_count % 2 == 0) begin
					high_char   = c;
					digit_count = digit_count + 1;
				end else begin
					idx          = digit_count / 2;
					decoded[idx] = {digit_value(high_char), digit_value(c)};
					if (idx + 1 >= ahfr_pkg::FRAME_BYTES) begin
						phase       = PH_TERM;
						digit_count = 0;
					end else begin
						digit_count = digit_count + 1;
					end
				end
			end
			PH_TERM: begin
				phase       = PH_HUNT;
				digit_count = 0;
				if (c == ahfr_pkg::CH_END) begin
					seq_byte = (ahfr_pkg::SN_POSITION < ahfr_pkg::FRAME_BYTES) ?
						decoded[ahfr_pkg::SN_IDX] : 8'h00;
					for (int k = 0; k < ahfr_pkg::FRAME_BYTES; k++) begin
						r.data = decoded[k];
						r.pos  = 3'(k);
						r.last = (k == ahfr_pkg::FRAME_BYTES - 1);
						r.seq  = seq_byte;
						expected_bytes.push_back(r);
					end
				end
			end
			default: begin
				phase = PH_HUNT;
			end
		endcase
	endfunction

	task report_mismatch(string what);
		errors++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	task check_byte(frame_result_t got);
		frame_result_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected byte %02h at position %0d",
				got.data, got.pos));
			return;
		end
		want = expected_bytes.pop_front();
		if (got.data !== want.data)
			report_mismatch($sformatf("frame_byte %02h, expected %02h", got.data, want.data));
		if (got.pos !== want.pos)
			report_mismatch($sformatf("byte_position %0d, expected %0d", got.pos, want.pos));
		if (got.last !== want.last)
			report_mismatch($sformatf("last_byte %0b, expected %0b", got.last, want.last));
		if (got.seq !== want.seq)
			report_mismatch($sformatf("sequence_byte %02h, expected %02h", got.seq, want.seq));
	endtask
endclass

module ascii_hex_frame_receiver_tb;
	localparam int RANDOM_ITEMS  = 435;
	localparam int QUIET_TAIL    = 60;
	localparam int STALL_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = 20;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_char;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] frame_byte;
	logic [2:0] byte_position;
	logic       last_byte;
	logic [7:0] sequence_byte;

	frame_byte_checker checker_h = new();

	bit sender_gaps   = 1'b0;
	bit receiver_gaps = 1'b0;
	int chars_sent    = 0;
	int stall_left    = 0;
	int quiet_cycles  = 0;

	const string HEX_DIGITS = "0123456789ABCDEFabcdef";

	ascii_hex_frame_receiver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_char       (rx_char),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.byte_position (byte_position),
		.last_byte     (last_byte),
		.sequence_byte (sequence_byte)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_char   = 8'h00;
		out_stall = 1'b0;
	end

	// Output stall comes in random bursts, started only while receiver_gaps is set.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (receiver_gaps && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.data = frame_byte;
			got.pos  = byte_position;
			got.last = last_byte;
			got.seq  = sequence_byte;
			checker_h.check_byte(got);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_char(input logic [7:0] c);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_char  <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		checker_h.take_char(c);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	// Mostly hex digits, now and then any byte at all.
	function automatic logic [7:0] data_char();
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom_range(0, 255));
		return HEX_DIGITS[$urandom_range(0, HEX_DIGITS.len() - 1)];
	endfunction

	function automatic logic [7:0] other_than(input logic [7:0] c);
		logic [7:0] pick;
		pick = 8'($urandom_range(0, 255));
		while (pick == c) pick = 8'($urandom_range(0, 255));
		return pick;
	endfunction

	task automatic send_digits(input int count);
		for (int i = 0; i < count; i++) send_char(data_char());
	endtask

	task automatic send_random_sequence();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			send_char(ahfr_pkg::CH_START);
			send_char(ahfr_pkg::CH_HEAD);
			send_digits(2 * ahfr_pkg::FRAME_BYTES);
			send_char(ahfr_pkg::CH_END);
		end else if (kind == 6) begin
			send_char(ahfr_pkg::CH_START);
			send_char(other_than(ahfr_pkg::CH_HEAD));
			send_digits($urandom_range(0, 4));
		end else if (kind == 7) begin
			send_char(ahfr_pkg::CH_START);
			send_char(ahfr_pkg::CH_HEAD);
			send_digits(2 * ahfr_pkg::FRAME_BYTES);
			send_char(other_than(ahfr_pkg::CH_END));
		end else if (kind == 8) begin
			// A start character cuts the frame short, possibly where the end belongs.
			send_char(ahfr_pkg::CH_START);
			send_char(ahfr_pkg::CH_HEAD);
			send_digits($urandom_range(0, 2 * ahfr_pkg::FRAME_BYTES));
			send_char(ahfr_pkg::CH_START);
		end else begin
			for (int i = $urandom_range(1, 6); i > 0; i--)
				send_char(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		bit paused_once;
		paused_once = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Extremes of the digits, lowercase and uppercase, non-hex digits,
		// then a bad header, noise while hunting and a restart inside the data.
		send_text("<F0F9afA>G00Ff7z19>");
		send_text("<QZ<F12<");

		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		while (chars_sent < RANDOM_ITEMS) begin
			if (chars_sent > 150 && chars_sent < 200) begin
				sender_gaps   = 1'b0;
				receiver_gaps = 1'b0;
			end else if (chars_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
				sender_gaps   = 1'b0;
				receiver_gaps = 1'b0;
			end else begin
				sender_gaps   = 1'b1;
				receiver_gaps = 1'b1;
			end
			if (!paused_once && chars_sent > 250) begin
				paused_once = 1'b1;
				in_valid <= 1'b0;
				while (checker_h.pending() != 0) @(negedge clk);
			end
			send_random_sequence();
		end
		in_valid <= 1'b0;

		while (checker_h.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (checker_h.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
